// File: rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int COORD_W = 16;
  localparam int CLASS_W = 7;
  localparam int CONF_W  = 16;
  localparam int THR_W   = 9;
  localparam int BOX_W   = 4 * COORD_W;
  localparam int ENTRY_W = BOX_W + CLASS_W;
  localparam int DATA_W  = 88;

  localparam logic [THR_W-1:0] THR_RESET = 9'd128;

  // Edge differences, areas and the union, all signed.
  localparam int DIFF_W  = COORD_W + 1;
  localparam int INTER_W = 2 * COORD_W;
  localparam int AREA_W  = 2 * DIFF_W - 1;
  localparam int UNI_W   = AREA_W + 2;

  // Shared multiplier: the union times the threshold is the widest product.
  localparam int MUL_A_W = UNI_W;
  localparam int MUL_B_W = DIFF_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int RATIO_W = UNI_W + THR_W;

  // Left edge in the lowest bits, as on the stream.
  typedef struct packed {
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } box_t;

  typedef enum logic [1:0] {
    MUL_AREA_B = 2'd0,
    MUL_INTER  = 2'd1,
    MUL_AREA_S = 2'd2,
    MUL_RATIO  = 2'd3
  } mul_op_t;

  typedef struct packed {
    box_t               new_box;
    box_t               kept_box;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [UNI_W-1:0]   uni;
    logic [THR_W-1:0]   thr;
  } mul_opnd_t;

endpackage

// File: rtl/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Per-class greedy suppression of overlapping boxes over a stream of
// candidates that arrive in priority order.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Word contents (lowest bits first)
//   -------  ---------  --------------------------------------------------
//   in_      slave      tdata: left, top, right, bottom, class, confidence
//                       tuser: start_of_frame
//   out_     master     tdata: left, top, right, bottom, class, confidence
//                       tuser: store_full
//   cfg_     write      wdata: overlap threshold (Q1.8)
//
// The time a box takes grows with the number of kept boxes it is checked
// against and with the number of those of the same class that overlap it.
// The kept-box memory port and the single multiplier set this: each kept
// box is read once, and each overlapping one needs four passes through the
// multiplier and the adder before the ratio test.
// in_tready is high only while the sequencer is idle. A finished word waits
// in the output register, so the next box can be taken while it is stalled.
// Reset clears the kept count and sets the threshold to one half; the
// memory itself is not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
module greedy_box_suppression #(
  parameter int MAX_KEPT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input words.
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // left_x, top_y, right_x, bottom_y, class, confidence, zero pad bit
  input  logic [gbs_pkg::DATA_W-1:0]  in_tdata,
  // start_of_frame
  input  logic                        in_tuser,
  // Result words.
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_left_x, out_top_y, out_right_x, out_bottom_y, out_class,
  // out_confidence, zero pad bit
  output logic [gbs_pkg::DATA_W-1:0]  out_tdata,
  // store_full
  output logic                        out_tuser,
  // Threshold register.
  input  logic                        cfg_we,
  input  logic [gbs_pkg::THR_W-1:0]   cfg_wdata
);

  localparam int AW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEPT);

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_AREAB = 10'b00_0000_0010,
    S_FETCH = 10'b00_0000_0100,
    S_TEST  = 10'b00_0000_1000,
    S_INTER = 10'b00_0001_0000,
    S_AREAS = 10'b00_0010_0000,
    S_UNION = 10'b00_0100_0000,
    S_RATIO = 10'b00_1000_0000,
    S_CMP   = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [gbs_pkg::THR_W-1:0]          thr_r;
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]                   idx_r, idx_nxt;
  logic [CNT_W-1:0]                   idx_inc;
  logic                               more;

  // The box under test.
  gbs_pkg::box_t                      box_r;
  logic [gbs_pkg::CLASS_W-1:0]        cls_r;
  logic [gbs_pkg::CONF_W-1:0]         conf_r;

  // Arithmetic results of the current comparison.
  logic signed [gbs_pkg::AREA_W-1:0]  area_b_r;
  logic signed [gbs_pkg::AREA_W-1:0]  area_s_r;
  logic [gbs_pkg::INTER_W-1:0]        inter_r;
  logic signed [gbs_pkg::UNI_W-1:0]   uni_r;
  logic signed [gbs_pkg::RATIO_W-1:0] ratio_r;
  logic [gbs_pkg::COORD_W-1:0]        dx_r, dy_r;

  // Output register.
  logic                               out_valid_r;
  logic [gbs_pkg::DATA_W-1:0]         out_data_r;
  logic                               out_full_r;

  // Memory and multiplier hookup.
  logic                               ram_re;
  logic [AW-1:0]                      ram_raddr;
  logic                               ram_we;
  logic [gbs_pkg::ENTRY_W-1:0]        ram_rdata;
  gbs_pkg::box_t                      kept_box;
  logic [gbs_pkg::CLASS_W-1:0]        kept_cls;
  gbs_pkg::mul_op_t                   mul_op;
  gbs_pkg::mul_opnd_t                 mul_opnd;
  logic signed [gbs_pkg::MUL_P_W-1:0] prod;

  // Intersection of the kept box just read with the box under test.
  logic signed [gbs_pkg::COORD_W-1:0] x1, y1, x2, y2;
  logic signed [gbs_pkg::DIFF_W-1:0]  dx, dy;
  logic                               hit;
  logic                               suppress;
  logic                               out_free;
  logic                               store_full;
  logic signed [gbs_pkg::UNI_W-1:0]   uni_sum;
  logic signed [gbs_pkg::RATIO_W-1:0] inter_scaled;

  assign kept_box = gbs_pkg::box_t'(ram_rdata[gbs_pkg::BOX_W-1:0]);
  assign kept_cls = ram_rdata[gbs_pkg::ENTRY_W-1:gbs_pkg::BOX_W];

  assign x1 = ($signed(kept_box.left) > $signed(box_r.left)) ?
              $signed(kept_box.left) : $signed(box_r.left);
  assign y1 = ($signed(kept_box.top) > $signed(box_r.top)) ?
              $signed(kept_box.top) : $signed(box_r.top);
  assign x2 = ($signed(kept_box.right) < $signed(box_r.right)) ?
              $signed(kept_box.right) : $signed(box_r.right);
  assign y2 = ($signed(kept_box.bottom) < $signed(box_r.bottom)) ?
              $signed(kept_box.bottom) : $signed(box_r.bottom);
  assign dx = gbs_pkg::DIFF_W'(x2) - gbs_pkg::DIFF_W'(x1);
  assign dy = gbs_pkg::DIFF_W'(y2) - gbs_pkg::DIFF_W'(y1);

  // Only a same-class kept box with a non-empty overlap needs the ratio test.
  assign hit = (kept_cls == cls_r) && (x2 > x1) && (y2 > y1);

  assign uni_sum = gbs_pkg::UNI_W'(area_s_r) + gbs_pkg::UNI_W'(area_b_r)
                 - $signed({2'b00, 1'b0, inter_r});
  assign inter_scaled = $signed({{(gbs_pkg::RATIO_W - gbs_pkg::INTER_W - 8){1'b0}},
                                 inter_r, 8'h00});

  // A positive union keeps the threshold product non-negative.
  assign suppress = !uni_r[gbs_pkg::UNI_W-1] && (uni_r != '0) &&
                    (inter_scaled > ratio_r);

  assign idx_inc    = idx_r + CNT_W'(1);
  assign more       = idx_inc < cnt_r;
  assign out_free   = !out_valid_r || out_tready;
  assign store_full = (cnt_r == MAX_CNT);

  assign mul_opnd.new_box  = box_r;
  assign mul_opnd.kept_box = kept_box;
  assign mul_opnd.dx       = dx_r;
  assign mul_opnd.dy       = dy_r;
  assign mul_opnd.uni      = uni_r;
  assign mul_opnd.thr      = thr_r;

  always_comb begin
    unique case (state_r)
      S_AREAB: mul_op = gbs_pkg::MUL_AREA_B;
      S_INTER: mul_op = gbs_pkg::MUL_INTER;
      S_AREAS: mul_op = gbs_pkg::MUL_AREA_S;
      default: mul_op = gbs_pkg::MUL_RATIO;
    endcase
  end

  // Sequencer: walks the kept list one entry at a time. Entries that miss
  // are retired without leaving S_TEST, since the next read is issued while the
  // current entry is tested.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    ram_re    = 1'b0;
    ram_raddr = idx_r[AW-1:0];
    ram_we    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_AREAB;
          if (in_tuser) begin
            cnt_nxt = '0;
          end
        end
      end
      S_AREAB: begin
        idx_nxt   = '0;
        state_nxt = (cnt_r == '0) ? S_EMIT : S_FETCH;
      end
      S_FETCH: begin
        ram_re    = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (hit) begin
          state_nxt = S_INTER;
        end else if (more) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[AW-1:0];
          idx_nxt   = idx_inc;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_INTER: state_nxt = S_AREAS;
      S_AREAS: state_nxt = S_UNION;
      S_UNION: state_nxt = S_RATIO;
      S_RATIO: state_nxt = S_CMP;
      S_CMP: begin
        if (suppress) begin
          state_nxt = S_IDLE;
        end else if (more) begin
          idx_nxt   = idx_inc;
          state_nxt = S_FETCH;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          if (!store_full) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      thr_r       <= gbs_pkg::THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      box_r  <= gbs_pkg::box_t'(in_tdata[gbs_pkg::BOX_W-1:0]);
      cls_r  <= in_tdata[gbs_pkg::ENTRY_W-1:gbs_pkg::BOX_W];
      conf_r <= in_tdata[gbs_pkg::ENTRY_W+gbs_pkg::CONF_W-1:gbs_pkg::ENTRY_W];
    end
    if (state_r == S_AREAB) begin
      area_b_r <= prod[gbs_pkg::AREA_W-1:0];
    end
    if (state_r == S_TEST) begin
      dx_r <= dx[gbs_pkg::COORD_W-1:0];
      dy_r <= dy[gbs_pkg::COORD_W-1:0];
    end
    if (state_r == S_INTER) begin
      inter_r <= prod[gbs_pkg::INTER_W-1:0];
    end
    if (state_r == S_AREAS) begin
      area_s_r <= prod[gbs_pkg::AREA_W-1:0];
    end
    if (state_r == S_UNION) begin
      uni_r <= uni_sum;
    end
    if (state_r == S_RATIO) begin
      ratio_r <= prod[gbs_pkg::RATIO_W-1:0];
    end
    if (state_r == S_EMIT && out_free) begin
      out_data_r <= {{(gbs_pkg::DATA_W - gbs_pkg::ENTRY_W - gbs_pkg::CONF_W){1'b0}},
                     conf_r, cls_r, box_r};
      out_full_r <= store_full;
    end
  end

  gbs_ram #(
    .WIDTH (gbs_pkg::ENTRY_W),
    .DEPTH (MAX_KEPT),
    .AW    (AW)
  ) u_kept (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({cls_r, box_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gbs_mul u_mul (
    .op   (mul_op),
    .opnd (mul_opnd),
    .prod (prod)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_full_r;

endmodule

// File: rtl/gbs_ram.sv
// ----------------------------------------------------------------------------
// gbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/gbs_mul.sv
// ----------------------------------------------------------------------------
// gbs_mul
// Shared signed multiplier with its operand selection.
// ----------------------------------------------------------------------------
module gbs_mul (
  input  gbs_pkg::mul_op_t                   op,
  input  gbs_pkg::mul_opnd_t                 opnd,
  output logic signed [gbs_pkg::MUL_P_W-1:0] prod
);

  logic signed [gbs_pkg::DIFF_W-1:0]  new_w;
  logic signed [gbs_pkg::DIFF_W-1:0]  new_h;
  logic signed [gbs_pkg::DIFF_W-1:0]  kept_w;
  logic signed [gbs_pkg::DIFF_W-1:0]  kept_h;
  logic signed [gbs_pkg::MUL_A_W-1:0] mul_a;
  logic signed [gbs_pkg::MUL_B_W-1:0] mul_b;

  // Widths and heights taken with one extra sign bit so they never wrap.
  assign new_w  = $signed({opnd.new_box.right[gbs_pkg::COORD_W-1], opnd.new_box.right})
                - $signed({opnd.new_box.left[gbs_pkg::COORD_W-1], opnd.new_box.left});
  assign new_h  = $signed({opnd.new_box.bottom[gbs_pkg::COORD_W-1], opnd.new_box.bottom})
                - $signed({opnd.new_box.top[gbs_pkg::COORD_W-1], opnd.new_box.top});
  assign kept_w = $signed({opnd.kept_box.right[gbs_pkg::COORD_W-1], opnd.kept_box.right})
                - $signed({opnd.kept_box.left[gbs_pkg::COORD_W-1], opnd.kept_box.left});
  assign kept_h = $signed({opnd.kept_box.bottom[gbs_pkg::COORD_W-1], opnd.kept_box.bottom})
                - $signed({opnd.kept_box.top[gbs_pkg::COORD_W-1], opnd.kept_box.top});

  always_comb begin
    unique case (op)
      gbs_pkg::MUL_AREA_B: begin
        mul_a = gbs_pkg::MUL_A_W'(new_w);
        mul_b = new_h;
      end
      gbs_pkg::MUL_INTER: begin
        mul_a = $signed({{(gbs_pkg::MUL_A_W - gbs_pkg::COORD_W){1'b0}}, opnd.dx});
        mul_b = $signed({1'b0, opnd.dy});
      end
      gbs_pkg::MUL_AREA_S: begin
        mul_a = gbs_pkg::MUL_A_W'(kept_w);
        mul_b = kept_h;
      end
      gbs_pkg::MUL_RATIO: begin
        mul_a = $signed(opnd.uni);
        mul_b = $signed({{(gbs_pkg::MUL_B_W - gbs_pkg::THR_W){1'b0}}, opnd.thr});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

endmodule
